// ===== hdl/c3dc_pkg.sv =====
// shared types and constants for the 3x3 convolution / divide / clamp block
// no dependencies; imported by every file but the checker
package c3dc_pkg;

    localparam int MaxWidth   = 1024;
    localparam int AddrBits   = $clog2(MaxWidth);
    localparam int WidthBits  = 11;
    localparam int RowLimit   = 4096;
    localparam int RowBits    = $clog2(RowLimit);
    localparam int HeightBits = 13;
    localparam int PixBits    = 8;
    localparam int CoefBits   = 16;
    localparam int CfgBits    = 3 * CoefBits;
    localparam int DivBits    = 15;
    localparam int QBits      = 8;
    localparam int ProdBits   = PixBits + 1 + CoefBits;
    localparam int ColSumBits = ProdBits + 2;
    localparam int SumBits    = ColSumBits + 2;
    localparam int RemBits    = DivBits + QBits;
    localparam int CfgIdxBits = 3;

    localparam logic [PixBits-1:0]    PixMax    = 8'd255;
    localparam logic [1:0]            PlaneLast = 2'd2;
    localparam logic [WidthBits-1:0]  WidthMin  = 11'd3;
    localparam logic [WidthBits-1:0]  WidthMax  = WidthBits'(MaxWidth);
    localparam logic [HeightBits-1:0] HeightMin = 13'd3;
    localparam logic [HeightBits-1:0] HeightMax = HeightBits'(RowLimit);

    // configuration register indexes
    localparam logic [CfgIdxBits-1:0] CFG_COEF_LEFT   = 3'd0;
    localparam logic [CfgIdxBits-1:0] CFG_COEF_MIDDLE = 3'd1;
    localparam logic [CfgIdxBits-1:0] CFG_COEF_RIGHT  = 3'd2;
    localparam logic [CfgIdxBits-1:0] CFG_DIVISOR     = 3'd3;
    localparam logic [CfgIdxBits-1:0] CFG_WIDTH       = 3'd4;
    localparam logic [CfgIdxBits-1:0] CFG_HEIGHT      = 3'd5;

    // [row][column], row 0 top, column 0 left
    typedef logic [2:0][2:0][PixBits-1:0] t_window;

    typedef struct packed {
        logic       valid;
        logic [1:0] plane;
        logic       last;
    } t_tag;

    typedef struct packed {
        t_tag               tag;
        logic               neg;
        logic               sat;
        logic [QBits-1:0]   q;
        logic [RemBits-1:0] rem;
    } t_div_tok;

endpackage

// ===== hdl/c3dc_line_window.sv =====
// line store pair (one memory, older/newer row packed per word) and 3x3 window
// depends on c3dc_pkg
module c3dc_line_window (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_accept,
    input  logic [c3dc_pkg::PixBits-1:0]  i_pixel,
    input  logic [c3dc_pkg::AddrBits-1:0] i_col,
    input  c3dc_pkg::t_tag                i_tag,
    output c3dc_pkg::t_window             o_window,
    output c3dc_pkg::t_tag                o_tag
);
    import c3dc_pkg::*;

    // [15:8] older row, [7:0] newer row
    logic [2*PixBits-1:0]  r_mem [MaxWidth];
    logic [2*PixBits-1:0]  r_rd;
    logic                  r_s1_v;
    logic [PixBits-1:0]    r_s1_px;
    logic [AddrBits-1:0]   r_s1_addr;
    t_tag                  r_s1_tag;
    t_window               r_window;
    t_tag                  r_win_tag;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rd      <= r_mem[i_col];
            r_s1_px   <= i_pixel;
            r_s1_addr <= i_col;
            if (r_s1_v) begin
                r_mem[r_s1_addr] <= {r_rd[PixBits-1:0], r_s1_px};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_s1_tag  <= '0;
            r_window  <= '0;
            r_win_tag <= '0;
        end else if (i_adv) begin
            r_s1_v    <= i_accept;
            r_s1_tag  <= i_accept ? i_tag : '0;
            r_win_tag <= r_s1_v ? r_s1_tag : '0;
            if (r_s1_v) begin
                for (int row = 0; row < 3; row++) begin
                    r_window[row][0] <= r_window[row][1];
                    r_window[row][1] <= r_window[row][2];
                end
                r_window[0][2] <= r_rd[2*PixBits-1:PixBits];
                r_window[1][2] <= r_rd[PixBits-1:0];
                r_window[2][2] <= r_s1_px;
            end
        end
    end

    assign o_window = r_window;
    assign o_tag    = r_win_tag;

endmodule

// ===== hdl/c3dc_mac.sv =====
// nine products, column sums and total of the 3x3 window, three register stages
// depends on c3dc_pkg
module c3dc_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  c3dc_pkg::t_window                   i_window,
    input  c3dc_pkg::t_tag                      i_tag,
    input  logic [c3dc_pkg::CfgBits-1:0]        i_coef_l,
    input  logic [c3dc_pkg::CfgBits-1:0]        i_coef_m,
    input  logic [c3dc_pkg::CfgBits-1:0]        i_coef_r,
    output logic signed [c3dc_pkg::SumBits-1:0] o_sum,
    output c3dc_pkg::t_tag                      o_tag
);
    import c3dc_pkg::*;

    logic signed [CoefBits-1:0]   w_coef [3][3];   // [column][row]
    logic signed [ProdBits-1:0]   n_prod [3][3];   // [row][column]
    logic signed [ProdBits-1:0]   r_prod [3][3];
    logic signed [ColSumBits-1:0] n_col [3];
    logic signed [ColSumBits-1:0] r_col [3];
    logic signed [SumBits-1:0]    n_sum;
    logic signed [SumBits-1:0]    r_sum;
    t_tag                         r_tag1;
    t_tag                         r_tag2;
    t_tag                         r_tag3;

    always_comb begin
        for (int row = 0; row < 3; row++) begin
            w_coef[0][row] = i_coef_l[row*CoefBits +: CoefBits];
            w_coef[1][row] = i_coef_m[row*CoefBits +: CoefBits];
            w_coef[2][row] = i_coef_r[row*CoefBits +: CoefBits];
        end
        for (int row = 0; row < 3; row++) begin
            for (int col = 0; col < 3; col++) begin
                n_prod[row][col] = ProdBits'($signed({1'b0, i_window[row][col]}))
                                 * ProdBits'(w_coef[col][row]);
            end
        end
        for (int col = 0; col < 3; col++) begin
            n_col[col] = ColSumBits'(r_prod[0][col]) + ColSumBits'(r_prod[1][col])
                       + ColSumBits'(r_prod[2][col]);
        end
        n_sum = SumBits'(r_col[0]) + SumBits'(r_col[1]) + SumBits'(r_col[2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= n_prod;
            r_col  <= n_col;
            r_sum  <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
        end else if (i_adv) begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
        end
    end

    assign o_sum = r_sum;
    assign o_tag = r_tag3;

endmodule

// ===== hdl/c3dc_div_cell.sv =====
// one restoring-division cell: compares against the shifted divisor, one quotient bit
// depends on c3dc_pkg; chained in the top level, one cell per quotient bit
module c3dc_div_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic [c3dc_pkg::RemBits-1:0] i_dsh,
    input  c3dc_pkg::t_div_tok           i_tok,
    output c3dc_pkg::t_div_tok           o_tok
);
    import c3dc_pkg::*;

    logic     w_ge;
    t_div_tok n_tok;
    t_div_tok r_tok;

    always_comb begin
        w_ge  = (i_tok.rem >= i_dsh);
        n_tok = i_tok;
        if (w_ge) begin
            n_tok.rem = i_tok.rem - i_dsh;
        end
        n_tok.q = {i_tok.q[QBits-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.tag.valid <= 1'b0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== hdl/conv3x3_divide_clamp_unit.sv =====
// 3x3 convolution, divide and clamp: takes one pixel per clock unless stalled; an
// accepted pixel passes the line store read, the window, 3 mac stages, divide
// setup, 8 division cells and the output register; every stage stalls together
// while the output register holds a result not yet taken
// reset (i_rst_n low, synchronous) clears counters, valids and config to defaults;
// the line store is not cleared
module conv3x3_divide_clamp_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] pixel_in
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,   // [7:0] filtered_pixel
    output logic [1:0]                      m_axis_tuser,   // [1:0] plane_index
    output logic                            m_axis_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [c3dc_pkg::CfgIdxBits-1:0] i_cfg_index,
    input  logic [c3dc_pkg::CfgBits-1:0]    i_cfg_data
);
    import c3dc_pkg::*;

    logic [CfgBits-1:0]    r_coef_l;
    logic [CfgBits-1:0]    r_coef_m;
    logic [CfgBits-1:0]    r_coef_r;
    logic [DivBits-1:0]    r_divisor;
    logic [WidthBits-1:0]  r_width;
    logic [HeightBits-1:0] r_height;

    logic [DivBits-1:0]    w_div_eff;
    logic [WidthBits-1:0]  w_width_eff;
    logic [HeightBits-1:0] w_height_eff;

    logic [AddrBits-1:0]   r_col;
    logic [RowBits-1:0]    r_row;
    logic [1:0]            r_plane;

    logic                  w_adv;
    logic                  w_accept;
    t_tag                  w_in_tag;
    t_window               w_window;
    t_tag                  w_win_tag;
    logic signed [SumBits-1:0] w_sum;
    t_tag                  w_sum_tag;
    t_div_tok              n_tok0;
    t_div_tok              r_tok0;
    t_div_tok              w_tok [QBits+1];
    logic [RemBits-1:0]    w_dsh [QBits];

    logic                  r_out_v;
    logic [PixBits-1:0]    r_out_data;
    logic [1:0]            r_out_plane;
    logic                  r_out_last;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_l  <= '0;
            r_coef_m  <= CfgBits'(65536);
            r_coef_r  <= '0;
            r_divisor <= DivBits'(1);
            r_width   <= WidthBits'(1024);
            r_height  <= HeightBits'(1024);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_COEF_LEFT:   r_coef_l  <= i_cfg_data;
                CFG_COEF_MIDDLE: r_coef_m  <= i_cfg_data;
                CFG_COEF_RIGHT:  r_coef_r  <= i_cfg_data;
                CFG_DIVISOR:     r_divisor <= i_cfg_data[DivBits-1:0];
                CFG_WIDTH:       r_width   <= i_cfg_data[WidthBits-1:0];
                CFG_HEIGHT:      r_height  <= i_cfg_data[HeightBits-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_div_eff = (r_divisor == '0) ? DivBits'(1) : r_divisor;
        if (r_width < WidthMin) begin
            w_width_eff = WidthMin;
        end else if (r_width > WidthMax) begin
            w_width_eff = WidthMax;
        end else begin
            w_width_eff = r_width;
        end
        if (r_height < HeightMin) begin
            w_height_eff = HeightMin;
        end else if (r_height > HeightMax) begin
            w_height_eff = HeightMax;
        end else begin
            w_height_eff = r_height;
        end
    end

    // whole pipeline moves whenever the output register can take a new value
    assign w_adv         = !r_out_v || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign w_accept      = s_axis_tvalid && w_adv;

    always_comb begin
        w_in_tag.valid = (r_col >= AddrBits'(2)) && (r_row >= RowBits'(2));
        w_in_tag.plane = r_plane;
        w_in_tag.last  = (WidthBits'(r_col) == w_width_eff - WidthBits'(1))
                      && (HeightBits'(r_row) == w_height_eff - HeightBits'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_plane <= '0;
        end else if (w_accept) begin
            if (WidthBits'(r_col) + WidthBits'(1) >= w_width_eff) begin
                r_col <= '0;
                if (HeightBits'(r_row) + HeightBits'(1) >= w_height_eff) begin
                    r_row   <= '0;
                    r_plane <= (r_plane >= PlaneLast) ? 2'd0 : r_plane + 2'd1;
                end else begin
                    r_row <= r_row + RowBits'(1);
                end
            end else begin
                r_col <= r_col + AddrBits'(1);
            end
        end
    end

    c3dc_line_window u_line_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_accept (w_accept),
        .i_pixel  (s_axis_tdata),
        .i_col    (r_col),
        .i_tag    (w_in_tag),
        .o_window (w_window),
        .o_tag    (w_win_tag)
    );

    c3dc_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_window (w_window),
        .i_tag    (w_win_tag),
        .i_coef_l (r_coef_l),
        .i_coef_m (r_coef_m),
        .i_coef_r (r_coef_r),
        .o_sum    (w_sum),
        .o_tag    (w_sum_tag)
    );

    // a negative sum clamps to zero, a sum of 256 divisors or more to the maximum;
    // otherwise the sum fits the remainder width and 8 cells find the quotient
    always_comb begin
        n_tok0.tag = w_sum_tag;
        n_tok0.neg = w_sum[SumBits-1];
        n_tok0.sat = !w_sum[SumBits-1]
                  && (w_sum[SumBits-2:0] >= (SumBits-1)'({w_div_eff, QBits'(0)}));
        n_tok0.q   = '0;
        n_tok0.rem = w_sum[RemBits-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok0.tag.valid <= 1'b0;
        end else if (w_adv) begin
            r_tok0 <= n_tok0;
        end
    end

    assign w_tok[0] = r_tok0;

    for (genvar k = 0; k < QBits; k++) begin : g_div
        assign w_dsh[k] = RemBits'(w_div_eff) << (QBits - 1 - k);

        c3dc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_dsh   (w_dsh[k]),
            .i_tok   (w_tok[k]),
            .o_tok   (w_tok[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= w_tok[QBits].tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_plane <= w_tok[QBits].tag.plane;
            r_out_last  <= w_tok[QBits].tag.last;
            if (w_tok[QBits].neg) begin
                r_out_data <= '0;
            end else if (w_tok[QBits].sat) begin
                r_out_data <= PixMax;
            end else begin
                r_out_data <= w_tok[QBits].q;
            end
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_plane;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== hdl/c3dc_checker.sv =====
// port-level checks on the convolution unit, bound to the top level
// depends on conv3x3_divide_clamp_unit
module c3dc_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tready,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [7:0]                      m_axis_tdata,
    input  logic [1:0]                      m_axis_tuser,
    input  logic                            m_axis_tlast
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // the pipeline freezes while the output is stalled
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_plane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser != 2'd3)
        else $error("plane index out of range");

endmodule

bind conv3x3_divide_clamp_unit c3dc_checker u_c3dc_checker (.*);

// ===== sim/tb_conv3x3_divide_clamp_unit.sv =====
`timescale 1ns / 1ps
// self-checking testbench for conv3x3_divide_clamp_unit: streams pixel planes through
// the block and checks each filtered pixel against a scoreboard that recomputes it
// depends on c3dc_pkg and the conv3x3_divide_clamp_unit rtl
module tb_conv3x3_divide_clamp_unit;

    import c3dc_pkg::*;

    localparam int RandomItems   = 520;
    localparam int HoldCycles    = 300;
    localparam int DrainCycles   = 20;
    localparam int WatchdogLimit = 3000;

    typedef struct {
        logic [PixBits-1:0] pix;
        logic [1:0]         plane;
        logic               eop;
    } t_filtered;

    typedef struct {
        logic [CfgBits-1:0]    left;
        logic [CfgBits-1:0]    middle;
        logic [CfgBits-1:0]    right;
        logic [DivBits-1:0]    div;
        logic [WidthBits-1:0]  width;
        logic [HeightBits-1:0] height;
    } t_kernel_setup;

    class conv_scoreboard;
        logic [CfgBits-1:0] kernel_col [3];
        int unsigned        div_val;
        int unsigned        width_val;
        int unsigned        height_val;
        bit [PixBits-1:0]   row_two_up [MaxWidth];
        bit [PixBits-1:0]   row_one_up [MaxWidth];
        bit [PixBits-1:0]   taps [3][3];
        int unsigned        x_pos;
        int unsigned        y_pos;
        int unsigned        plane_no;
        t_filtered          filtered_q [$];
        int                 mismatches;

        function new();
            kernel_col[0] = '0;
            kernel_col[1] = CfgBits'(48'h1_0000);
            kernel_col[2] = '0;
            div_val       = 1;
            width_val     = MaxWidth;
            height_val    = 1024;
            x_pos         = 0;
            y_pos         = 0;
            plane_no      = 0;
            mismatches    = 0;
        endfunction

        function void set_reg(logic [CfgIdxBits-1:0] idx, logic [CfgBits-1:0] data);
            case (idx)
                CFG_COEF_LEFT:   kernel_col[0] = data;
                CFG_COEF_MIDDLE: kernel_col[1] = data;
                CFG_COEF_RIGHT:  kernel_col[2] = data;
                CFG_DIVISOR:     div_val = data[DivBits-1:0];
                CFG_WIDTH:       width_val = data[WidthBits-1:0];
                CFG_HEIGHT:      height_val = data[HeightBits-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_width();
            if (width_val < WidthMin) return WidthMin;
            if (width_val > WidthMax) return WidthMax;
            return width_val;
        endfunction

        function int unsigned eff_height();
            if (height_val < HeightMin) return HeightMin;
            if (height_val > HeightMax) return HeightMax;
            return height_val;
        endfunction

        function bit plane_start();
            return x_pos == 0 && y_pos == 0;
        endfunction

        function int pending();
            return filtered_q.size();
        endfunction

        // weight of one window row, two's complement within its column register
        function longint weight_at(logic [CfgBits-1:0] col, int row);
            return longint'($signed(col[row*CoefBits +: CoefBits]));
        endfunction

        function void accept_pixel(logic [PixBits-1:0] px);
            int unsigned w, h, c, r;
            int          i, j;
            longint      acc, d, q;
            t_filtered   res;
            w = eff_width();
            h = eff_height();
            c = x_pos;
            r = y_pos;
            for (i = 0; i < 3; i++) begin
                taps[i][0] = taps[i][1];
                taps[i][1] = taps[i][2];
            end
            taps[0][2] = row_two_up[c];
            taps[1][2] = row_one_up[c];
            taps[2][2] = px;
            row_two_up[c] = row_one_up[c];
            row_one_up[c] = px;
            if (c >= 2 && r >= 2) begin
                acc = 0;
                for (i = 0; i < 3; i++) begin
                    for (j = 0; j < 3; j++) begin
                        acc += longint'(taps[i][j]) * weight_at(kernel_col[j], i);
                    end
                end
                // a zero divisor acts as one; division truncates toward zero
                d = (div_val == 0) ? 1 : longint'(div_val);
                q = acc / d;
                if (q < 0) q = 0;
                if (q > 255) q = 255;
                res.pix   = PixBits'(q);
                res.plane = 2'(plane_no);
                res.eop   = (c == w - 1) && (r == h - 1);
                filtered_q.push_back(res);
            end
            // counters past a lowered limit wrap at the end of this pixel
            if (c + 1 >= w) begin
                x_pos = 0;
                if (r + 1 >= h) begin
                    y_pos    = 0;
                    plane_no = (plane_no >= int'(PlaneLast)) ? 0 : plane_no + 1;
                end else begin
                    y_pos = r + 1;
                end
            end else begin
                x_pos = c + 1;
            end
        endfunction

        function void check_filtered(logic [PixBits-1:0] pix, logic [1:0] plane, logic eop);
            t_filtered want;
            if (filtered_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: pixel %0d plane %0d last %0d", pix, plane, eop);
                mismatches++;
                return;
            end
            want = filtered_q.pop_front();
            if (pix !== want.pix || plane !== want.plane || eop !== want.eop) begin
                if (mismatches < 10)
                    $display("mismatch at %0t: pixel %0d/%0d plane %0d/%0d last %0d/%0d (exp/act)",
                             $realtime, want.pix, pix, want.plane, plane, want.eop, eop);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CfgIdxBits-1:0] i_cfg_index   = CFG_COEF_LEFT;
    logic [CfgBits-1:0]    i_cfg_data    = '0;

    conv_scoreboard sb = new();
    t_kernel_setup  setup;
    int             pixels_sent  = 0;
    int             src_quiet    = 0;
    int             sink_quiet   = 0;
    int             stall_cycles = 0;
    bit             sink_hold_req = 1'b0;

    conv3x3_divide_clamp_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // mostly no gap, some short ones, a few long, and now and then a quiet stretch
    function automatic int pick_gap(ref int quiet_left);
        int roll;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            quiet_left = $urandom_range(20, 120);
            return 0;
        end
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [PixBits-1:0] random_pixel();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return PixMax;
        return PixBits'($urandom_range(0, 255));
    endfunction

    function automatic logic [CoefBits-1:0] random_weight();
        int roll;
        roll = $urandom_range(0, 9);
        case (roll)
            0:       return {1'b1, {(CoefBits-1){1'b0}}};
            1:       return {1'b0, {(CoefBits-1){1'b1}}};
            2, 3:    return CoefBits'($urandom);
            default: return CoefBits'($urandom_range(0, 12)) - CoefBits'(4);
        endcase
    endfunction

    function automatic logic [CfgBits-1:0] random_column();
        return {random_weight(), random_weight(), random_weight()};
    endfunction

    function automatic logic [DivBits-1:0] random_divisor();
        int roll;
        roll = $urandom_range(0, 9);
        case (roll)
            0:       return '0;
            1:       return '1;
            2:       return DivBits'($urandom_range(1, 32767));
            default: return DivBits'($urandom_range(1, 48));
        endcase
    endfunction

    function automatic t_kernel_setup random_setup();
        t_kernel_setup s;
        int            roll;
        s.left   = random_column();
        s.middle = random_column();
        s.right  = random_column();
        s.div    = random_divisor();
        roll = $urandom_range(0, 19);
        if (roll == 0)      s.width = WidthBits'($urandom_range(0, 2));
        else if (roll == 1) s.width = WidthBits'($urandom_range(11, 20));
        else                s.width = WidthBits'($urandom_range(3, 10));
        roll = $urandom_range(0, 19);
        if (roll == 0)      s.height = HeightBits'($urandom_range(0, 2));
        else if (roll == 1) s.height = HeightBits'($urandom_range(9, 14));
        else                s.height = HeightBits'($urandom_range(3, 8));
        return s;
    endfunction

    task automatic cfg_write(input logic [CfgIdxBits-1:0] idx, input logic [CfgBits-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
    endtask

    // unused upper data bits carry noise on the narrow registers
    task automatic program_regs(input t_kernel_setup s);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        cfg_write(CFG_COEF_LEFT, s.left);
        cfg_write(CFG_COEF_MIDDLE, s.middle);
        cfg_write(CFG_COEF_RIGHT, s.right);
        cfg_write(CFG_DIVISOR, {junk[CfgBits-1:DivBits], s.div});
        cfg_write(CFG_WIDTH, {junk[CfgBits-1:WidthBits], s.width});
        cfg_write(CFG_HEIGHT, {junk[CfgBits-1:HeightBits], s.height});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(input logic [PixBits-1:0] px);
        int gap;
        gap = pick_gap(src_quiet);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.accept_pixel(px);
        pixels_sent++;
    endtask

    // pixels that make no result may still be in the pipe after the last result
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // one plane from its first pixel; a size change mid-plane only ever narrows
    // the width, so no row reads line store entries left unwritten
    task automatic run_plane(input bit allow_split);
        int split, n;
        split = 0;
        n     = 0;
        if (allow_split && $urandom_range(0, 3) == 0)
            split = $urandom_range(1, sb.eff_width() * sb.eff_height() - 1);
        do begin
            send_pixel(random_pixel());
            n++;
            if (n == split) begin
                wait_idle();
                setup.width  = WidthBits'($urandom_range(0, sb.eff_width()));
                setup.height = HeightBits'($urandom_range(0, 12));
                program_regs(setup);
            end
        end while (!sb.plane_start());
    endtask

    // starts a plane on the programmed sizes, then caps the width and sets a small height
    task automatic run_cut_plane(input int head);
        int w_cap;
        repeat (head) send_pixel(random_pixel());
        wait_idle();
        w_cap = (sb.eff_width() < 6) ? int'(sb.eff_width()) : 6;
        setup.width  = WidthBits'($urandom_range(3, w_cap));
        setup.height = HeightBits'($urandom_range(3, 6));
        program_regs(setup);
        while (!sb.plane_start()) send_pixel(random_pixel());
    endtask

    initial begin : sink_driver
        int stall;
        forever begin
            if (sink_hold_req) begin
                // long hold so the pipe fills and back-pressures the input
                m_axis_tready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
                sink_hold_req = 1'b0;
            end else begin
                stall = pick_gap(sink_quiet);
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_filtered(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WatchdogLimit) begin
                $display("conv3x3_divide_clamp_unit verification failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int i, planes;
        bit hold_done;
        hold_done = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // largest positive weights, zero divisor, full-scale pixels: clamps high
        setup.left   = {3{16'h7FFF}};
        setup.middle = {3{16'h7FFF}};
        setup.right  = {3{16'h7FFF}};
        setup.div    = '0;
        setup.width  = WidthBits'(3);
        setup.height = HeightBits'(3);
        program_regs(setup);
        repeat (9) send_pixel(PixMax);
        wait_idle();

        // most negative weights, largest divisor, sizes below the minimum: clamps low
        setup.left   = {3{16'h8000}};
        setup.middle = {3{16'h8000}};
        setup.right  = {3{16'h8000}};
        setup.div    = '1;
        setup.width  = '0;
        setup.height = HeightBits'(1);
        program_regs(setup);
        for (i = 0; i < 9; i++) send_pixel((i % 2 == 0) ? PixMax : 8'h5A);
        wait_idle();

        // center tap only with a divisor that truncates; ends plane 2 so planes wrap
        setup.left   = '0;
        setup.middle = {16'h0000, 16'd7, 16'h0000};
        setup.right  = '0;
        setup.div    = DivBits'(3);
        setup.width  = WidthBits'(2);
        setup.height = HeightBits'(2);
        program_regs(setup);
        for (i = 0; i < 9; i++) send_pixel((i < 8) ? PixBits'(1 << i) : PixMax);
        wait_idle();

        while (pixels_sent < RandomItems) begin
            setup = random_setup();
            if (!hold_done) begin
                setup.width  = WidthBits'(5);
                setup.height = HeightBits'(10);
            end
            program_regs(setup);
            if (!hold_done) begin
                sink_hold_req = 1'b1;
                hold_done     = 1'b1;
            end
            planes = $urandom_range(1, 3);
            for (i = 0; i < planes; i++) run_plane(1'b1);
            wait_idle();
        end

        // widest rows, then tallest plane, through saturating register values;
        // each plane is cut to small sizes after a short head so it stays short
        setup = random_setup();
        setup.width  = '1;
        setup.height = HeightBits'(3);
        program_regs(setup);
        run_cut_plane($urandom_range(24, 40));
        wait_idle();

        setup = random_setup();
        setup.width  = WidthBits'(3);
        setup.height = '1;
        program_regs(setup);
        run_cut_plane($urandom_range(30, 60));
        wait_idle();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("conv3x3_divide_clamp_unit verification clean");
        else
            $display("conv3x3_divide_clamp_unit verification failed");
        $finish;
    end

endmodule

// ===== conv3x3_divide_clamp_unit.f =====
hdl/c3dc_pkg.sv
hdl/c3dc_line_window.sv
hdl/c3dc_mac.sv
hdl/c3dc_div_cell.sv
hdl/conv3x3_divide_clamp_unit.sv
hdl/c3dc_checker.sv
sim/tb_conv3x3_divide_clamp_unit.sv
